/* rtl/clim_pkg.sv */
// ----------------------------------------------------------------------------
// clim_pkg - shared definitions for the connection attempt limiter
// Register indexes, reset values, verdict codes and the command and status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package clim_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;

  localparam int ADDR_W = 32;
  localparam int TIME_W = 48;
  localparam int CNT_W  = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BURST  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAST   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EXTEND = 3'd4;

  // reset values
  localparam logic [15:0] WINDOW_RST = 16'd5000;
  localparam logic [3:0]  BURST_RST  = 4'd5;
  localparam logic [15:0] FAST_RST   = 16'd500;
  localparam logic [15:0] BLOCK_RST  = 16'd3000;
  localparam logic [15:0] EXTEND_RST = 16'd250;

  // verdict codes
  localparam logic [2:0] V_NEW           = 3'd0;
  localparam logic [2:0] V_OK            = 3'd1;
  localparam logic [2:0] V_BLOCKED       = 3'd2;
  localparam logic [2:0] V_NEWLY_BLOCKED = 3'd3;
  localparam logic [2:0] V_FULL          = 3'd4;

  typedef struct packed {
    logic load;        // capture the accepted word, restart the scan
    logic scan;        // step the table search
    logic eval;        // time compare and gap
    logic commit_hit;  // update the matched entry, load the result
    logic commit_miss; // place a new entry or report full, load the result
  } cmd_t;

  typedef struct packed {
    logic empty;     // no entries stored
    logic hit;       // compare stage matched
    logic scan_end;  // compare stage passed the last stored entry, no match
    logic out_free;  // output register can take a result this cycle
  } sts_t;

endpackage

/* rtl/clim_ctrl.sv */
// ----------------------------------------------------------------------------
// clim_ctrl - sequencing for the connection attempt limiter
// Steps each word through search, evaluation (on a match) and commit.
// ----------------------------------------------------------------------------
module clim_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  clim_pkg::sts_t sts,
  output clim_pkg::cmd_t cmd,
  output logic          in_ready
);
  import clim_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_HIT  = 3'd3;
  localparam logic [2:0] S_MISS = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load  = 1'b1;
          state_nxt = sts.empty ? S_MISS : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          state_nxt = S_EVAL;
        end else if (sts.scan_end) begin
          state_nxt = S_MISS;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = S_HIT;
      end
      S_HIT: begin
        if (sts.out_free) begin
          cmd.commit_hit = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_MISS: begin
        if (sts.out_free) begin
          cmd.commit_miss = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/clim_dp.sv */
// ----------------------------------------------------------------------------
// clim_dp - datapath of the connection attempt limiter
// Entry table, fill count, search pipeline, time arithmetic, config
// registers and the output register.
// ----------------------------------------------------------------------------
module clim_dp #(
  parameter int TABLE_ENTRIES = clim_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  clim_pkg::cmd_t                    cmd,
  output clim_pkg::sts_t                    sts,
  input  logic [clim_pkg::ADDR_W-1:0]       in_addr,
  input  logic [clim_pkg::TIME_W-1:0]       in_now,
  input  logic                              cfg_fire,
  input  logic [clim_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [clim_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_admitted,
  output logic [2:0]                        out_verdict
);
  import clim_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_ENTRIES);

  // config registers
  logic [15:0] window_r, fast_r, block_r, extend_r;
  logic [3:0]  burst_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RST;
      burst_r  <= BURST_RST;
      fast_r   <= FAST_RST;
      block_r  <= BLOCK_RST;
      extend_r <= EXTEND_RST;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        REG_WINDOW: window_r <= cfg_data;
        REG_BURST:  burst_r  <= cfg_data[3:0];
        REG_FAST:   fast_r   <= cfg_data;
        REG_BLOCK:  block_r  <= cfg_data;
        REG_EXTEND: extend_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // entry table; slots 0 .. fill-1 are the valid ones
  logic [ADDR_W-1:0] addr_mem [TABLE_ENTRIES];
  logic [TIME_W-1:0] ls_mem   [TABLE_ENTRIES];
  logic [TIME_W-1:0] bu_mem   [TABLE_ENTRIES];
  logic [CNT_W-1:0]  cnt_mem  [TABLE_ENTRIES];

  logic [CW-1:0]     fill_r, scan_cnt_r;
  logic              cmp_vld_r;
  logic [IW-1:0]     cmp_idx_r, hit_idx_r;
  logic [ADDR_W-1:0] addr_r, addr_q_r;
  logic [TIME_W-1:0] now_r, ls_q_r, bu_q_r;
  logic [CNT_W-1:0]  cnt_q_r;
  logic              blocked_r;
  logic [TIME_W-1:0] gap_r;
  logic              out_valid_r, out_adm_r;
  logic [2:0]        out_verdict_r;

  logic              issue_ok, hit, last_cmp, table_full;
  logic              wr_en;
  logic [IW-1:0]     wr_idx;
  logic [ADDR_W-1:0] wr_addr;
  logic [TIME_W-1:0] wr_ls, wr_bu;
  logic [CNT_W-1:0]  wr_cnt;
  logic              res_adm;
  logic [2:0]        res_verdict;

  logic [TIME_W:0]   diff;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] sat_sum, sum_base;
  logic [15:0]       sum_inc;
  logic              gap_win, gap_fast, burst;
  logic [CNT_W-1:0]  cnt_inc;

  assign issue_ok   = scan_cnt_r < fill_r;
  assign hit        = cmp_vld_r && (addr_q_r == addr_r);
  assign last_cmp   = (CW'(cmp_idx_r) + CW'(1)) == fill_r;
  assign table_full = fill_r == FULL_CNT;

  assign sts.empty    = fill_r == '0;
  assign sts.hit      = hit;
  assign sts.scan_end = cmp_vld_r && !hit && last_cmp;
  assign sts.out_free = !out_valid_r || out_ready;

  // word capture and search pipeline: one address read per cycle, compared
  // in the cycle after; the record of the compared slot is read alongside
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r  <= 1'b0;
      scan_cnt_r <= '0;
    end else begin
      cmp_vld_r <= cmd.scan && issue_ok;
      if (cmd.load) begin
        scan_cnt_r <= '0;
      end else if (cmd.scan && issue_ok) begin
        scan_cnt_r <= scan_cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_r <= in_addr;
      now_r  <= in_now;
    end
    if (cmd.scan && issue_ok) begin
      addr_q_r  <= addr_mem[scan_cnt_r[IW-1:0]];
      cmp_idx_r <= scan_cnt_r[IW-1:0];
    end
    if (cmd.scan) begin
      ls_q_r    <= ls_mem[cmp_idx_r];
      bu_q_r    <= bu_mem[cmp_idx_r];
      cnt_q_r   <= cnt_mem[cmp_idx_r];
      hit_idx_r <= cmp_idx_r;
    end
  end

  // evaluation: blocked test and gap, time going backwards gives zero
  assign diff = {1'b0, now_r} - {1'b0, ls_q_r};

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      blocked_r <= bu_q_r > now_r;
      gap_r     <= diff[TIME_W] ? '0 : diff[TIME_W-1:0];
    end
  end

  // commit: one saturating add, narrow compares
  assign sum_base = blocked_r ? bu_q_r : now_r;
  assign sum_inc  = blocked_r ? extend_r : block_r;
  assign sum      = {1'b0, sum_base} + (TIME_W+1)'(sum_inc);
  assign sat_sum  = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
  assign gap_win  = (gap_r[TIME_W-1:16] == '0) && (gap_r[15:0] <= window_r);
  assign gap_fast = (gap_r[TIME_W-1:16] == '0) && (gap_r[15:0] <= fast_r);
  assign cnt_inc  = cnt_q_r + CNT_W'(1);
  assign burst    = cnt_inc > {1'b0, burst_r};

  // the compare register has moved on past the matched slot by now, so the
  // matched address is taken from the captured word
  always_comb begin
    wr_en       = 1'b0;
    wr_idx      = hit_idx_r;
    wr_addr     = addr_r;
    wr_ls       = ls_q_r;
    wr_bu       = bu_q_r;
    wr_cnt      = cnt_q_r;
    res_adm     = 1'b1;
    res_verdict = V_OK;
    if (cmd.commit_hit) begin
      wr_en = 1'b1;
      if (blocked_r) begin
        wr_bu       = sat_sum;
        res_adm     = 1'b0;
        res_verdict = V_BLOCKED;
      end else begin
        wr_ls = now_r;
        if (gap_win) begin
          if (burst) begin
            wr_cnt = '0;
            if (gap_fast) begin
              wr_bu       = sat_sum;
              res_adm     = 1'b0;
              res_verdict = V_NEWLY_BLOCKED;
            end
          end else begin
            wr_cnt = cnt_inc;
          end
        end else begin
          wr_cnt = CNT_W'(1);
        end
      end
    end else if (cmd.commit_miss) begin
      if (table_full) begin
        res_verdict = V_FULL;
      end else begin
        wr_en       = 1'b1;
        wr_idx      = fill_r[IW-1:0];
        wr_addr     = addr_r;
        wr_ls       = now_r;
        wr_bu       = '0;
        wr_cnt      = CNT_W'(1);
        res_verdict = V_NEW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      addr_mem[wr_idx] <= wr_addr;
      ls_mem[wr_idx]   <= wr_ls;
      bu_mem[wr_idx]   <= wr_bu;
      cnt_mem[wr_idx]  <= wr_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit_miss && !table_full) begin
        fill_r <= fill_r + CW'(1);
      end
      if (cmd.commit_hit || cmd.commit_miss) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit_hit || cmd.commit_miss) begin
      out_adm_r     <= res_adm;
      out_verdict_r <= res_verdict;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_admitted = out_adm_r;
  assign out_verdict  = out_verdict_r;

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_CNT)
    else $error("fill count beyond table size");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit_miss && !table_full |=> fill_r == $past(fill_r) + CW'(1))
    else $error("new entry did not advance fill count");

  a_hit_stored: assert property (@(posedge clk) disable iff (!rst_n)
    hit |-> CW'(cmp_idx_r) < fill_r)
    else $error("match on a slot that was never filled");

  a_reject_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_adm_r |->
      (out_verdict_r == V_BLOCKED) || (out_verdict_r == V_NEWLY_BLOCKED))
    else $error("reject with a non-blocking verdict");

endmodule

/* rtl/connection_attempt_limiter.sv */
// ----------------------------------------------------------------------------
// connection_attempt_limiter - per-source admission filter
// Tracks connecting addresses, counts bursts of attempts and blocks sources
// that retry too fast; one verdict word per attempt word.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              payload
//  in_      slave      in_tvalid/in_tready    in_tdata[79:0]: address, time
//  out_     master     out_tvalid/out_tready  out_tdata[7:0]: admitted, verdict
//  cfg_     slave      cfg_valid/cfg_ready    cfg_index[2:0], cfg_data[15:0]
//
// Search: one word is processed at a time. The table search reads one stored
// address per cycle from the address memory; a known address in slot k is
// evaluated once the scan reaches slot k, then committed; an unknown one is
// committed after all stored entries are scanned, straight from capture if empty.
// Reset: config registers return to defaults and the fill count clears; the
// table itself is not swept, slots beyond the fill count are never read.
// Stalls: the result sits in the output register and the next word is taken
// meanwhile; that word's result waits in the commit step until the register
// frees. cfg_ready is always high; write only while idle.
// ----------------------------------------------------------------------------
module connection_attempt_limiter #(
  parameter int TABLE_ENTRIES = clim_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // [31:0] source_address, [79:32] now_ms
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] admitted, [3:1] verdict, [7:4] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import clim_pkg::*;

  cmd_t       cmd;
  sts_t       sts;
  logic       in_fire;
  logic       admitted;
  logic [2:0] verdict;

  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // sequencer: search, evaluate on a match, commit
  clim_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_tready)
  );

  // table, arithmetic, config and output register
  clim_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_addr      (in_tdata[31:0]),
    .in_now       (in_tdata[79:32]),
    .cfg_fire     (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_admitted (admitted),
    .out_verdict  (verdict)
  );

  // result word, zero padded to a byte
  assign out_tdata = {4'b0000, verdict, admitted};

endmodule
